// File: design/htr_pkg.sv
package htr_pkg;

  // Default sizes, handed to the top level parameters
  localparam int NUM_TRACKS_DEF  = 4;
  localparam int TRACK_DEPTH_DEF = 8;
  localparam int CAR_BITS_DEF    = 8;

  // Move counter width and its saturation value
  localparam int              MOVE_BITS = 16;
  localparam logic [MOVE_BITS-1:0] MOVE_MAX  = '1;

  // Event codes on the result channel
  typedef enum logic [1:0] {
    EV_PLACE   = 2'd0,
    EV_DIRECT  = 2'd1,
    EV_RELEASE = 2'd2,
    EV_REJECT  = 2'd3
  } event_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_FETCH
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming car
    logic decide;  // direct departure, placement or reject
    logic scan;    // send pending result, pop a matching track top
    logic fetch;   // refill the popped track's top from the store
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic direct;     // held car is the expected number
    logic rel_found;  // a track top equals the expected number
  } dp_sts_t;

endpackage

// File: design/holding_track_reorder_top.sv
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+----------------------------
// input    | in_car                                       | start & !busy takes a beat
// result   | out_event_res, out_car_out, out_track,       | out_valid for one cycle,
//          | out_tracks_used, out_moves, out_next_number, | no back-pressure
//          | out_last                                     |
//
// A placed or rejected car passes through the decide state, and the block is then idle.
// A direct departure goes on to scan, and each car released from a track adds a fetch:
// the fetch waits for the track store read that refills the track top.
// Direct and release results wait in a pending register; each is shown for exactly one cycle.
// Synchronous active-low reset empties all tracks and sets the expected car to one;
// no clearing pass is needed. The receiver cannot stall the block.
module holding_track_reorder_top #(
  parameter int NUM_TRACKS  = htr_pkg::NUM_TRACKS_DEF,
  parameter int TRACK_DEPTH = htr_pkg::TRACK_DEPTH_DEF,
  parameter int CAR_BITS    = htr_pkg::CAR_BITS_DEF,
  localparam int TW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1,
  localparam int OW = $clog2(NUM_TRACKS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [CAR_BITS-1:0]           in_car,
  output logic                          out_valid,
  output logic [1:0]                    out_event_res,
  output logic [CAR_BITS-1:0]           out_car_out,
  output logic [TW-1:0]                 out_track,
  output logic [OW-1:0]                 out_tracks_used,
  output logic [htr_pkg::MOVE_BITS-1:0] out_moves,
  output logic [CAR_BITS:0]             out_next_number,
  output logic                          out_last
);
  import htr_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequencer
  htr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Tracks, counters and result register
  htr_dp #(
    .NUM_TRACKS  (NUM_TRACKS),
    .TRACK_DEPTH (TRACK_DEPTH),
    .CAR_BITS    (CAR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_car          (in_car),
    .out_valid       (out_valid),
    .out_event_res   (out_event_res),
    .out_car_out     (out_car_out),
    .out_track       (out_track),
    .out_tracks_used (out_tracks_used),
    .out_moves       (out_moves),
    .out_next_number (out_next_number),
    .out_last        (out_last)
  );

endmodule

// File: design/htr_ctrl.sv
module htr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  htr_pkg::dp_sts_t   sts,
  output htr_pkg::ctrl_cmd_t cmd
);
  import htr_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.direct ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = sts.rel_found ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_SCAN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/htr_dp.sv
module htr_dp #(
  parameter int NUM_TRACKS  = htr_pkg::NUM_TRACKS_DEF,
  parameter int TRACK_DEPTH = htr_pkg::TRACK_DEPTH_DEF,
  parameter int CAR_BITS    = htr_pkg::CAR_BITS_DEF,
  localparam int TW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1,
  localparam int OW = $clog2(NUM_TRACKS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  htr_pkg::ctrl_cmd_t           cmd,
  output htr_pkg::dp_sts_t             sts,
  input  logic [CAR_BITS-1:0]          in_car,
  output logic                         out_valid,
  output logic [1:0]                   out_event_res,
  output logic [CAR_BITS-1:0]          out_car_out,
  output logic [TW-1:0]                out_track,
  output logic [OW-1:0]                out_tracks_used,
  output logic [htr_pkg::MOVE_BITS-1:0] out_moves,
  output logic [CAR_BITS:0]            out_next_number,
  output logic                         out_last
);
  import htr_pkg::*;

  localparam int EW    = CAR_BITS + 1;
  localparam int HW    = $clog2(TRACK_DEPTH + 1);
  localparam int DW    = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
  localparam int SLOTS = NUM_TRACKS * TRACK_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Held car, cached track tops, fill counts
  logic [CAR_BITS-1:0]  car_r;
  logic [CAR_BITS-1:0]  top_r    [NUM_TRACKS];
  logic [HW-1:0]        height_r [NUM_TRACKS];
  logic [EW-1:0]        expected_r, expected_nxt;
  logic [OW-1:0]        opened_r, opened_nxt;
  logic [MOVE_BITS-1:0] moves_r, moves_nxt;

  // Result waiting for its last flag
  event_t               pend_ev_r;
  logic [CAR_BITS-1:0]  pend_car_r;
  logic [TW-1:0]        pend_trk_r;

  // Top refill after a pop
  logic [TW-1:0]        rel_trk_r;
  logic                 rel_more_r;
  logic [CAR_BITS-1:0]  rd_data_r;
  logic [CAR_BITS-1:0]  mem [SLOTS];

  // Output register
  logic                 out_valid_r;
  event_t               out_ev_r;
  logic [CAR_BITS-1:0]  out_car_r;
  logic [TW-1:0]        out_trk_r;
  logic [OW-1:0]        out_used_r;
  logic [MOVE_BITS-1:0] out_moves_r;
  logic [EW-1:0]        out_next_r;
  logic                 out_last_r;

  // Search results
  logic          direct;
  logic          gt_found, emp_found, rel_found;
  logic [TW-1:0] gt_idx, emp_idx, rel_idx;
  logic          place_found, reject;
  logic [TW-1:0] place_idx;
  logic [HW-1:0] place_h, rel_h, rel_h_left, rd_h;
  logic [AW-1:0] wr_addr, rd_addr;

  // Per-track compares, lowest index wins
  always_comb begin
    gt_found  = 1'b0;
    gt_idx    = '0;
    emp_found = 1'b0;
    emp_idx   = '0;
    rel_found = 1'b0;
    rel_idx   = '0;
    for (int i = 0; i < NUM_TRACKS; i++) begin
      if (!gt_found && height_r[i] != '0 && car_r < top_r[i]) begin
        gt_found = 1'b1;
        gt_idx   = TW'(i);
      end
      if (!emp_found && height_r[i] == '0) begin
        emp_found = 1'b1;
        emp_idx   = TW'(i);
      end
      if (!rel_found && height_r[i] != '0 && {1'b0, top_r[i]} == expected_r) begin
        rel_found = 1'b1;
        rel_idx   = TW'(i);
      end
    end
  end

  // Placement choice and counter updates
  always_comb begin
    direct       = ({1'b0, car_r} == expected_r);
    place_found  = gt_found | emp_found;
    place_idx    = gt_found ? gt_idx : emp_idx;
    place_h      = height_r[place_idx];
    reject       = !place_found || (place_h == HW'(TRACK_DEPTH));
    rel_h        = height_r[rel_idx];
    rel_h_left   = rel_h - HW'(1);
    rd_h         = rel_h - HW'(2);
    wr_addr      = AW'(AW'(place_idx) * AW'(TRACK_DEPTH)) + AW'(place_h[DW-1:0]);
    rd_addr      = AW'(AW'(rel_idx) * AW'(TRACK_DEPTH)) + AW'(rd_h[DW-1:0]);
    expected_nxt = expected_r + EW'(1);
    moves_nxt    = (moves_r == MOVE_MAX) ? moves_r : moves_r + MOVE_BITS'(1);
    opened_nxt   = ((OW'(place_idx) + OW'(1)) > opened_r) ? OW'(place_idx) + OW'(1)
                                                          : opened_r;
  end

  assign sts.direct    = direct;
  assign sts.rel_found = rel_found;

  // Control state: fill counts, counters, strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TRACKS; i++) begin
        height_r[i] <= '0;
      end
      expected_r  <= EW'(1);
      opened_r    <= '0;
      moves_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.decide && !direct) || cmd.scan;
      if (cmd.decide) begin
        if (direct) begin
          expected_r <= expected_nxt;
          moves_r    <= moves_nxt;
        end else if (!reject) begin
          height_r[place_idx] <= place_h + HW'(1);
          opened_r            <= opened_nxt;
          moves_r             <= moves_nxt;
        end
      end
      if (cmd.scan && rel_found) begin
        height_r[rel_idx] <= rel_h_left;
        expected_r        <= expected_nxt;
        moves_r           <= moves_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      car_r <= in_car;
    end
    if (cmd.decide) begin
      if (direct) begin
        pend_ev_r  <= EV_DIRECT;
        pend_car_r <= car_r;
        pend_trk_r <= '0;
      end else begin
        out_ev_r    <= reject ? EV_REJECT : EV_PLACE;
        out_car_r   <= car_r;
        out_trk_r   <= reject ? '0 : place_idx;
        out_used_r  <= reject ? opened_r : opened_nxt;
        out_moves_r <= reject ? moves_r : moves_nxt;
        out_next_r  <= expected_r;
        out_last_r  <= 1'b1;
        if (!reject) begin
          top_r[place_idx] <= car_r;
        end
      end
    end
    if (cmd.scan) begin
      // counters already reflect the pending beat
      out_ev_r    <= pend_ev_r;
      out_car_r   <= pend_car_r;
      out_trk_r   <= pend_trk_r;
      out_used_r  <= opened_r;
      out_moves_r <= moves_r;
      out_next_r  <= expected_r;
      out_last_r  <= !rel_found;
      if (rel_found) begin
        pend_ev_r  <= EV_RELEASE;
        pend_car_r <= expected_r[CAR_BITS-1:0];
        pend_trk_r <= rel_idx;
        rel_trk_r  <= rel_idx;
        rel_more_r <= (rel_h_left != '0);
      end
    end
    if (cmd.fetch && rel_more_r) begin
      top_r[rel_trk_r] <= rd_data_r;
    end
  end

  // Track store: write on placement, read the slot under a popped top
  always_ff @(posedge clk) begin
    if (cmd.decide && !direct && !reject) begin
      mem[wr_addr] <= car_r;
    end
    if (cmd.scan && rel_found) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_ev_r;
  assign out_car_out     = out_car_r;
  assign out_track       = out_trk_r;
  assign out_tracks_used = out_used_r;
  assign out_moves       = out_moves_r;
  assign out_next_number = out_next_r;
  assign out_last        = out_last_r;

endmodule
